// ===== rtl/four_wheel_drive_pwm_mixer_defines.svh =====
// ---------------------------------------------------------------------------
// Four-wheel drive PWM mixer: assertion macros
// Shared checking helpers; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef FOUR_WHEEL_DRIVE_PWM_MIXER_DEFINES_SVH
`define FOUR_WHEEL_DRIVE_PWM_MIXER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FWDPM_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FWDPM_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fwdpm_pkg.sv =====
// ---------------------------------------------------------------------------
// fwdpm_pkg
// Types, command codes, register map and scaling table of the drive mixer.
// ---------------------------------------------------------------------------
package fwdpm_pkg;

  localparam int PCT_W    = 7;
  localparam int WIDTH_W  = 16;
  localparam int PERIOD_W = 16;
  localparam int PINS_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int CORR_W   = 8;
  localparam int CMD_W    = 5;
  localparam int STATE_W  = 3;
  localparam int MIX_W    = 10;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int LANES    = 4;

  localparam int PCT_FULL = 100;

  // width = (period * ceil(pct * 2^23 / 100)) >> 23 is exact for 16-bit periods
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_BRAKE      = 5'd0,
    CMD_COAST      = 5'd1,
    CMD_FWD        = 5'd2,
    CMD_REV        = 5'd3,
    CMD_CW         = 5'd4,
    CMD_CCW        = 5'd5,
    CMD_STRAFE_L   = 5'd6,
    CMD_STRAFE_R   = 5'd7,
    CMD_TRIM_FWD   = 5'd8,
    CMD_TRIM_REV   = 5'd9,
    CMD_TRIM_LEFT  = 5'd10,
    CMD_TRIM_RIGHT = 5'd11,
    CMD_PAN_DUTY   = 5'd12,
    CMD_TILT_DUTY  = 5'd13,
    CMD_PAN_LEFT   = 5'd14,
    CMD_PAN_CENTER = 5'd15,
    CMD_PAN_RIGHT  = 5'd16
  } cmd_t;

  typedef enum logic [STATE_W-1:0] {
    DS_IDLE     = 3'd0,
    DS_FWD      = 3'd1,
    DS_REV      = 3'd2,
    DS_CW       = 3'd3,
    DS_CCW      = 3'd4,
    DS_STRAFE_L = 3'd5,
    DS_STRAFE_R = 3'd6
  } drive_state_t;

  typedef enum logic [2:0] {
    REG_UPPER_LIMIT = 3'd0,
    REG_LOWER_LIMIT = 3'd1,
    REG_MOTOR_PER   = 3'd2,
    REG_PAN_PER     = 3'd3,
    REG_TILT_PER    = 3'd4,
    REG_PAN_LEFT    = 3'd5,
    REG_PAN_CENTER  = 3'd6,
    REG_PAN_RIGHT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PCT_W-1:0]    upper_limit;
    logic [PCT_W-1:0]    lower_limit;
    logic [PERIOD_W-1:0] motor_period;
    logic [PERIOD_W-1:0] pan_period;
    logic [PERIOD_W-1:0] tilt_period;
    logic [PCT_W-1:0]    pan_left_duty;
    logic [PCT_W-1:0]    pan_center_duty;
    logic [PCT_W-1:0]    pan_right_duty;
  } cfg_t;

  typedef logic [LANES-1:0][PCT_W-1:0] lane_pct_t;

  // H-bridge pattern per drive state; idle and the unused code drive nothing
  localparam logic [PINS_W-1:0] STATE_PINS [8] = '{
    8'h00, 8'h55, 8'hAA, 8'h99, 8'h66, 8'h96, 8'h69, 8'h00
  };

  typedef logic [RECIP_W-1:0] recip_tbl_t [128];

  function automatic recip_tbl_t build_recip_tbl();
    recip_tbl_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = RECIP_W'(((longint'(i) << RECIP_SHIFT) + PCT_FULL - 1) / PCT_FULL);
    end
    return t;
  endfunction

  localparam recip_tbl_t RECIP_TBL = build_recip_tbl();

  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] d);
    return (d > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : d;
  endfunction

endpackage

// ===== rtl/fwdpm_if.sv =====
// ---------------------------------------------------------------------------
// fwdpm_if
// Valid/ready channels for drive commands and the reported drive status.
// ---------------------------------------------------------------------------
interface fwdpm_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [fwdpm_pkg::CMD_W-1:0]          command;
  logic [fwdpm_pkg::PCT_W-1:0]          duty;
  logic [fwdpm_pkg::COUNT_W-1:0]        move_target;
  logic signed [fwdpm_pkg::CORR_W-1:0]  correction_a;
  logic signed [fwdpm_pkg::CORR_W-1:0]  correction_b;

  modport source (output valid, command, duty, move_target, correction_a, correction_b,
                  input ready);
  modport sink   (input valid, command, duty, move_target, correction_a, correction_b,
                  output ready);
endinterface

interface fwdpm_res_if;
  logic                                valid;
  logic                                ready;
  logic [fwdpm_pkg::WIDTH_W-1:0]       width_m1;
  logic [fwdpm_pkg::WIDTH_W-1:0]       width_m2;
  logic [fwdpm_pkg::WIDTH_W-1:0]       width_m3;
  logic [fwdpm_pkg::WIDTH_W-1:0]       width_m4;
  logic [fwdpm_pkg::PINS_W-1:0]        bridge_pins;
  logic [fwdpm_pkg::WIDTH_W-1:0]       pan_width;
  logic [fwdpm_pkg::WIDTH_W-1:0]       tilt_width;
  logic [fwdpm_pkg::STATE_W-1:0]       drive_state;
  logic [fwdpm_pkg::COUNT_W-1:0]       move_count;

  modport source (output valid, width_m1, width_m2, width_m3, width_m4, bridge_pins,
                  pan_width, tilt_width, drive_state, move_count,
                  input ready);
  modport sink   (input valid, width_m1, width_m2, width_m3, width_m4, bridge_pins,
                  pan_width, tilt_width, drive_state, move_count,
                  output ready);
endinterface

// ===== rtl/fwdpm_cfg.sv =====
// ---------------------------------------------------------------------------
// fwdpm_cfg
// APB-style register file holding limits, periods and pan presets.
// ---------------------------------------------------------------------------
module fwdpm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fwdpm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fwdpm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fwdpm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output fwdpm_pkg::cfg_t                     cfg
);

  fwdpm_pkg::cfg_t     cfg_r;
  fwdpm_pkg::reg_idx_t idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = fwdpm_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_limit     <= fwdpm_pkg::PCT_W'(fwdpm_pkg::PCT_FULL);
      cfg_r.lower_limit     <= '0;
      cfg_r.motor_period    <= fwdpm_pkg::PERIOD_W'(1000);
      cfg_r.pan_period      <= fwdpm_pkg::PERIOD_W'(1000);
      cfg_r.tilt_period     <= fwdpm_pkg::PERIOD_W'(1000);
      cfg_r.pan_left_duty   <= '0;
      cfg_r.pan_center_duty <= '0;
      cfg_r.pan_right_duty  <= '0;
    end else if (wr_en) begin
      case (idx)
        fwdpm_pkg::REG_UPPER_LIMIT: cfg_r.upper_limit     <= pwdata[fwdpm_pkg::PCT_W-1:0];
        fwdpm_pkg::REG_LOWER_LIMIT: cfg_r.lower_limit     <= pwdata[fwdpm_pkg::PCT_W-1:0];
        fwdpm_pkg::REG_MOTOR_PER:   cfg_r.motor_period    <= pwdata[fwdpm_pkg::PERIOD_W-1:0];
        fwdpm_pkg::REG_PAN_PER:     cfg_r.pan_period      <= pwdata[fwdpm_pkg::PERIOD_W-1:0];
        fwdpm_pkg::REG_TILT_PER:    cfg_r.tilt_period     <= pwdata[fwdpm_pkg::PERIOD_W-1:0];
        fwdpm_pkg::REG_PAN_LEFT:    cfg_r.pan_left_duty   <= pwdata[fwdpm_pkg::PCT_W-1:0];
        fwdpm_pkg::REG_PAN_CENTER:  cfg_r.pan_center_duty <= pwdata[fwdpm_pkg::PCT_W-1:0];
        fwdpm_pkg::REG_PAN_RIGHT:   cfg_r.pan_right_duty  <= pwdata[fwdpm_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      fwdpm_pkg::REG_UPPER_LIMIT: prdata = 32'(cfg_r.upper_limit);
      fwdpm_pkg::REG_LOWER_LIMIT: prdata = 32'(cfg_r.lower_limit);
      fwdpm_pkg::REG_MOTOR_PER:   prdata = 32'(cfg_r.motor_period);
      fwdpm_pkg::REG_PAN_PER:     prdata = 32'(cfg_r.pan_period);
      fwdpm_pkg::REG_TILT_PER:    prdata = 32'(cfg_r.tilt_period);
      fwdpm_pkg::REG_PAN_LEFT:    prdata = 32'(cfg_r.pan_left_duty);
      fwdpm_pkg::REG_PAN_CENTER:  prdata = 32'(cfg_r.pan_center_duty);
      fwdpm_pkg::REG_PAN_RIGHT:   prdata = 32'(cfg_r.pan_right_duty);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/fwdpm_mix.sv =====
// ---------------------------------------------------------------------------
// fwdpm_mix
// Trim mixer: duty plus or minus the corrections, clamped per motor.
// ---------------------------------------------------------------------------
module fwdpm_mix (
  input  logic [fwdpm_pkg::CMD_W-1:0]         cmd,
  input  logic [fwdpm_pkg::PCT_W-1:0]         duty,
  input  logic signed [fwdpm_pkg::CORR_W-1:0] corr_a,
  input  logic signed [fwdpm_pkg::CORR_W-1:0] corr_b,
  input  logic [fwdpm_pkg::PCT_W-1:0]         upper_limit,
  input  logic [fwdpm_pkg::PCT_W-1:0]         lower_limit,
  output fwdpm_pkg::lane_pct_t                lane_pct
);

  localparam int MW = fwdpm_pkg::MIX_W;

  logic signed [MW-1:0] d_s, a_s, b_s, up_s, lo_s;
  logic signed [MW-1:0] dpa, dma, dpb, dmb;
  logic signed [MW-1:0] mix [fwdpm_pkg::LANES];
  logic signed [MW-1:0] clamped [fwdpm_pkg::LANES];

  assign d_s  = signed'(MW'(duty));
  assign a_s  = MW'(corr_a);
  assign b_s  = MW'(corr_b);
  assign up_s = signed'(MW'(upper_limit));
  assign lo_s = signed'(MW'(lower_limit));

  assign dpa = d_s + a_s;
  assign dma = d_s - a_s;
  assign dpb = d_s + b_s;
  assign dmb = d_s - b_s;

  // Pick the sign pattern of each trim mode
  always_comb begin
    mix[0] = dma; mix[1] = dpa; mix[2] = dpb; mix[3] = dmb;
    case (cmd)
      fwdpm_pkg::CMD_TRIM_REV: begin
        mix[0] = dpa; mix[1] = dma; mix[2] = dmb; mix[3] = dpb;
      end
      fwdpm_pkg::CMD_TRIM_LEFT: begin
        mix[0] = dpa; mix[1] = dmb; mix[2] = dma; mix[3] = dpb;
      end
      fwdpm_pkg::CMD_TRIM_RIGHT: begin
        mix[0] = dma; mix[1] = dpb; mix[2] = dpa; mix[3] = dmb;
      end
      default: ;
    endcase
  end

  // Upper limit is tested first; with crossed limits, values above it take the upper one, all others the lower one
  always_comb begin
    for (int k = 0; k < fwdpm_pkg::LANES; k++) begin
      if (mix[k] > up_s) begin
        clamped[k] = up_s;
      end else if (mix[k] < lo_s) begin
        clamped[k] = lo_s;
      end else begin
        clamped[k] = mix[k];
      end
      lane_pct[k] = fwdpm_pkg::sat_pct(clamped[k][fwdpm_pkg::PCT_W-1:0]);
    end
  end

endmodule

// ===== rtl/fwdpm_scale.sv =====
// ---------------------------------------------------------------------------
// fwdpm_scale
// Percent to pulse width: pct * period / 100 via a reciprocal table.
// ---------------------------------------------------------------------------
module fwdpm_scale #(
  parameter int PERIOD_BITS = 16
) (
  input  logic [fwdpm_pkg::PCT_W-1:0]    pct,
  input  logic [fwdpm_pkg::PERIOD_W-1:0] period,
  output logic [fwdpm_pkg::WIDTH_W-1:0]  width
);

  localparam int PW       = fwdpm_pkg::PERIOD_W;
  localparam int EFF_BITS = (PERIOD_BITS < PW) ? PERIOD_BITS : PW;
  localparam logic [PW-1:0] PERIOD_MASK = PW'((64'(1) << EFF_BITS) - 64'(1));
  localparam int PROD_W   = PW + fwdpm_pkg::RECIP_W;

  logic [PW-1:0]                    per_m;
  logic [fwdpm_pkg::RECIP_W-1:0]    recip;
  logic [PROD_W-1:0]                prod;

  assign per_m = period & PERIOD_MASK;
  assign recip = fwdpm_pkg::RECIP_TBL[pct];
  assign prod  = PROD_W'(per_m) * PROD_W'(recip);
  assign width = prod[fwdpm_pkg::RECIP_SHIFT +: fwdpm_pkg::WIDTH_W];

endmodule

// ===== rtl/four_wheel_drive_pwm_mixer.sv =====
// ---------------------------------------------------------------------------
// four_wheel_drive_pwm_mixer
// Drive command mixer for four motors, H-bridge pins and a pan/tilt head.
// ---------------------------------------------------------------------------
// An accepted command passes the command register, then the status register, before
//   its status is valid on out_chan. Throughput: 1 item per cycle while out_chan is ready; the
//   two registers form a two-entry pipeline, so a new item is taken while a status waits.
// Per item: one pass of mix, clamp and one 16x24 table multiply per lane.
// Reset (rst_n low, synchronous): widths, pins, state and count clear to zero,
//   registers return to their defaults, both channels go empty.
// ---------------------------------------------------------------------------
`include "four_wheel_drive_pwm_mixer_defines.svh"

module four_wheel_drive_pwm_mixer #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fwdpm_cmd_if.sink                         in_chan,
  fwdpm_res_if.source                       out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fwdpm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fwdpm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fwdpm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int LN = fwdpm_pkg::LANES;

  fwdpm_pkg::cfg_t cfg;

  // Command register
  logic                                 s1_valid_r;
  logic [fwdpm_pkg::CMD_W-1:0]          s1_cmd_r;
  logic [fwdpm_pkg::PCT_W-1:0]          s1_duty_r;
  logic [fwdpm_pkg::COUNT_W-1:0]        s1_target_r;
  logic signed [fwdpm_pkg::CORR_W-1:0]  s1_a_r;
  logic signed [fwdpm_pkg::CORR_W-1:0]  s1_b_r;

  // Status register; it is the drive state itself, reported after every item
  logic                                 out_valid_r;
  logic [fwdpm_pkg::WIDTH_W-1:0]        widths_r   [LN];
  logic [fwdpm_pkg::WIDTH_W-1:0]        widths_nxt [LN];
  logic [fwdpm_pkg::PINS_W-1:0]         pins_r, pins_nxt;
  logic [fwdpm_pkg::WIDTH_W-1:0]        pan_r, pan_nxt;
  logic [fwdpm_pkg::WIDTH_W-1:0]        tilt_r, tilt_nxt;
  fwdpm_pkg::drive_state_t              mode_r, mode_nxt;
  logic [fwdpm_pkg::COUNT_W-1:0]        count_r, count_nxt;

  logic                                 adv;
  logic [fwdpm_pkg::PCT_W-1:0]          duty_sat;
  logic [fwdpm_pkg::STATE_W-1:0]        move_state;
  fwdpm_pkg::lane_pct_t                 trim_pct;
  fwdpm_pkg::lane_pct_t                 lane_pct;
  logic [fwdpm_pkg::PERIOD_W-1:0]       lane_per [LN];
  logic [fwdpm_pkg::WIDTH_W-1:0]        lane_w   [LN];

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  fwdpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // -------------------------------------------------------------------------
  // Handshake: advance the command into the status register whenever the
  // status slot is free or being drained this cycle.
  // -------------------------------------------------------------------------
  assign adv           = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // Hold payload until the next accepted item
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_cmd_r    <= in_chan.command;
      s1_duty_r   <= in_chan.duty;
      s1_target_r <= in_chan.move_target;
      s1_a_r      <= in_chan.correction_a;
      s1_b_r      <= in_chan.correction_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // Datapath: trim mixing, then one scaler per motor lane. Lane 0 also
  // serves moves and the pan/tilt servos, which never coincide with trims.
  // -------------------------------------------------------------------------
  assign duty_sat   = fwdpm_pkg::sat_pct(s1_duty_r);
  assign move_state = fwdpm_pkg::STATE_W'(s1_cmd_r - fwdpm_pkg::CMD_W'(fwdpm_pkg::CMD_COAST));

  fwdpm_mix u_mix (
    .cmd         (s1_cmd_r),
    .duty        (duty_sat),
    .corr_a      (s1_a_r),
    .corr_b      (s1_b_r),
    .upper_limit (cfg.upper_limit),
    .lower_limit (cfg.lower_limit),
    .lane_pct    (trim_pct)
  );

  always_comb begin
    lane_pct = trim_pct;
    for (int k = 0; k < LN; k++) begin
      lane_per[k] = cfg.motor_period;
    end
    case (s1_cmd_r)
      fwdpm_pkg::CMD_TRIM_FWD, fwdpm_pkg::CMD_TRIM_REV,
      fwdpm_pkg::CMD_TRIM_LEFT, fwdpm_pkg::CMD_TRIM_RIGHT: ;
      fwdpm_pkg::CMD_PAN_DUTY: begin
        lane_pct[0] = duty_sat;
        lane_per[0] = cfg.pan_period;
      end
      fwdpm_pkg::CMD_TILT_DUTY: begin
        lane_pct[0] = duty_sat;
        lane_per[0] = cfg.tilt_period;
      end
      fwdpm_pkg::CMD_PAN_LEFT: begin
        lane_pct[0] = fwdpm_pkg::sat_pct(cfg.pan_left_duty);
        lane_per[0] = cfg.pan_period;
      end
      fwdpm_pkg::CMD_PAN_CENTER: begin
        lane_pct[0] = fwdpm_pkg::sat_pct(cfg.pan_center_duty);
        lane_per[0] = cfg.pan_period;
      end
      fwdpm_pkg::CMD_PAN_RIGHT: begin
        lane_pct[0] = fwdpm_pkg::sat_pct(cfg.pan_right_duty);
        lane_per[0] = cfg.pan_period;
      end
      default: begin
        lane_pct[0] = duty_sat;
      end
    endcase
  end

  for (genvar g = 0; g < LN; g++) begin : g_lane
    fwdpm_scale #(
      .PERIOD_BITS (PERIOD_BITS)
    ) u_scale (
      .pct    (lane_pct[g]),
      .period (lane_per[g]),
      .width  (lane_w[g])
    );
  end

  // -------------------------------------------------------------------------
  // Next drive state per command; unused codes leave everything as is
  // -------------------------------------------------------------------------
  always_comb begin
    widths_nxt = widths_r;
    pins_nxt   = pins_r;
    pan_nxt    = pan_r;
    tilt_nxt   = tilt_r;
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    case (s1_cmd_r)
      fwdpm_pkg::CMD_BRAKE: begin
        pins_nxt = '0;
        mode_nxt = fwdpm_pkg::DS_IDLE;
      end
      fwdpm_pkg::CMD_COAST: begin
        for (int k = 0; k < LN; k++) begin
          widths_nxt[k] = '0;
        end
        mode_nxt = fwdpm_pkg::DS_IDLE;
      end
      fwdpm_pkg::CMD_FWD, fwdpm_pkg::CMD_REV, fwdpm_pkg::CMD_CW,
      fwdpm_pkg::CMD_CCW, fwdpm_pkg::CMD_STRAFE_L, fwdpm_pkg::CMD_STRAFE_R: begin
        for (int k = 0; k < LN; k++) begin
          widths_nxt[k] = lane_w[0];
        end
        pins_nxt  = fwdpm_pkg::STATE_PINS[move_state];
        mode_nxt  = fwdpm_pkg::drive_state_t'(move_state);
        count_nxt = s1_target_r;
      end
      fwdpm_pkg::CMD_TRIM_FWD, fwdpm_pkg::CMD_TRIM_REV,
      fwdpm_pkg::CMD_TRIM_LEFT, fwdpm_pkg::CMD_TRIM_RIGHT: begin
        widths_nxt = lane_w;
      end
      fwdpm_pkg::CMD_PAN_DUTY, fwdpm_pkg::CMD_PAN_LEFT,
      fwdpm_pkg::CMD_PAN_CENTER, fwdpm_pkg::CMD_PAN_RIGHT: begin
        pan_nxt = lane_w[0];
      end
      fwdpm_pkg::CMD_TILT_DUTY: begin
        tilt_nxt = lane_w[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LN; k++) begin
        widths_r[k] <= '0;
      end
      pins_r  <= '0;
      pan_r   <= '0;
      tilt_r  <= '0;
      mode_r  <= fwdpm_pkg::DS_IDLE;
      count_r <= '0;
    end else if (adv) begin
      widths_r <= widths_nxt;
      pins_r   <= pins_nxt;
      pan_r    <= pan_nxt;
      tilt_r   <= tilt_nxt;
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Status channel
  // -------------------------------------------------------------------------
  assign out_chan.valid       = out_valid_r;
  assign out_chan.width_m1    = widths_r[0];
  assign out_chan.width_m2    = widths_r[1];
  assign out_chan.width_m3    = widths_r[2];
  assign out_chan.width_m4    = widths_r[3];
  assign out_chan.bridge_pins = pins_r;
  assign out_chan.pan_width   = pan_r;
  assign out_chan.tilt_width  = tilt_r;
  assign out_chan.drive_state = mode_r;
  assign out_chan.move_count  = count_r;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `FWDPM_AST_NEXT(a_hold_state, !adv, $stable(pins_r) && $stable(mode_r) && $stable(count_r), "drive state changed without an item")
  `FWDPM_AST_SAME(a_pins_match, mode_r != fwdpm_pkg::DS_IDLE, pins_r == fwdpm_pkg::STATE_PINS[mode_r], "bridge pins disagree with drive state")
  `FWDPM_AST_NEXT(a_adv_valid, adv, out_valid_r, "advanced item not presented")

endmodule

// ===== bench/tb_four_wheel_drive_pwm_mixer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_four_wheel_drive_pwm_mixer
// Self-checking bench for the drive mixer. It sends directed and random drive
// commands under several register settings and idle patterns. Every reported
// status is checked field by field against a predicted copy of the mixer.
// ---------------------------------------------------------------------------
module tb_four_wheel_drive_pwm_mixer;

  localparam int CMD_W      = fwdpm_pkg::CMD_W;
  localparam int PCT_W      = fwdpm_pkg::PCT_W;
  localparam int COUNT_W    = fwdpm_pkg::COUNT_W;
  localparam int CORR_W     = fwdpm_pkg::CORR_W;
  localparam int WIDTH_W    = fwdpm_pkg::WIDTH_W;
  localparam int PINS_W     = fwdpm_pkg::PINS_W;
  localparam int PERIOD_W   = fwdpm_pkg::PERIOD_W;
  localparam int CFG_ADDR_W = fwdpm_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = fwdpm_pkg::CFG_DATA_W;
  localparam int LANES      = fwdpm_pkg::LANES;
  localparam int PCT_FULL   = fwdpm_pkg::PCT_FULL;

  // Command codes that the mixer ignores; they still report the status.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 5'd17;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 5'd31;

  localparam int RANDOM_PER_PHASE = 150;
  localparam int SETTLE_CYCLES    = 4;      // two-stage pipeline plus margin
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT      = 200000;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [PCT_W-1:0]          duty;
    logic [COUNT_W-1:0]        target;
    logic signed [CORR_W-1:0]  corr_a;
    logic signed [CORR_W-1:0]  corr_b;
  } drive_cmd_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]      m1;
    logic [WIDTH_W-1:0]      m2;
    logic [WIDTH_W-1:0]      m3;
    logic [WIDTH_W-1:0]      m4;
    logic [PINS_W-1:0]       pins;
    logic [WIDTH_W-1:0]      pan;
    logic [WIDTH_W-1:0]      tilt;
    fwdpm_pkg::drive_state_t state;
    logic [COUNT_W-1:0]      count;
  } drive_status_t;

  // -------------------------------------------------------------------------
  // Predicted mixer state and the queue of statuses still owed by the block.
  // -------------------------------------------------------------------------
  class drive_status_board;
    fwdpm_pkg::cfg_t         cfg;
    logic [WIDTH_W-1:0]      motor_w [LANES];
    logic [PINS_W-1:0]       pins;
    logic [WIDTH_W-1:0]      pan_w;
    logic [WIDTH_W-1:0]      tilt_w;
    fwdpm_pkg::drive_state_t mode;
    logic [COUNT_W-1:0]      moves;
    drive_status_t           owed [$];
    int                      mismatches;

    function new();
      cfg.upper_limit     = 7'd100;
      cfg.lower_limit     = 7'd0;
      cfg.motor_period    = 16'd1000;
      cfg.pan_period      = 16'd1000;
      cfg.tilt_period     = 16'd1000;
      cfg.pan_left_duty   = 7'd0;
      cfg.pan_center_duty = 7'd0;
      cfg.pan_right_duty  = 7'd0;
      foreach (motor_w[k]) motor_w[k] = '0;
      pins       = '0;
      pan_w      = '0;
      tilt_w     = '0;
      mode       = fwdpm_pkg::DS_IDLE;
      moves      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(fwdpm_pkg::reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        fwdpm_pkg::REG_UPPER_LIMIT: cfg.upper_limit     = v[PCT_W-1:0];
        fwdpm_pkg::REG_LOWER_LIMIT: cfg.lower_limit     = v[PCT_W-1:0];
        fwdpm_pkg::REG_MOTOR_PER:   cfg.motor_period    = v[PERIOD_W-1:0];
        fwdpm_pkg::REG_PAN_PER:     cfg.pan_period      = v[PERIOD_W-1:0];
        fwdpm_pkg::REG_TILT_PER:    cfg.tilt_period     = v[PERIOD_W-1:0];
        fwdpm_pkg::REG_PAN_LEFT:    cfg.pan_left_duty   = v[PCT_W-1:0];
        fwdpm_pkg::REG_PAN_CENTER:  cfg.pan_center_duty = v[PCT_W-1:0];
        fwdpm_pkg::REG_PAN_RIGHT:   cfg.pan_right_duty  = v[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    function int cap_pct(int d);
      return (d > PCT_FULL) ? PCT_FULL : d;
    endfunction

    function logic [WIDTH_W-1:0] pct_to_counts(int pct, logic [PERIOD_W-1:0] period);
      longint unsigned prod;
      prod = longint'(pct) * longint'(period) / PCT_FULL;
      return prod[WIDTH_W-1:0];
    endfunction

    // Upper limit is tested first; with crossed limits, values above it land on the upper one, the rest on the lower.
    function int clamp_trim(int v);
      if (v > int'(cfg.upper_limit)) v = cfg.upper_limit;
      else if (v < int'(cfg.lower_limit)) v = cfg.lower_limit;
      return cap_pct(v);
    endfunction

    function void note_cmd(drive_cmd_t c);
      int d, a, b, idx;
      int mix [LANES];
      bit trim;
      logic [WIDTH_W-1:0] w;
      d    = cap_pct(c.duty);
      a    = c.corr_a;
      b    = c.corr_b;
      trim = 1'b0;
      case (c.command)
        fwdpm_pkg::CMD_BRAKE: begin
          pins = '0;
          mode = fwdpm_pkg::DS_IDLE;
        end
        fwdpm_pkg::CMD_COAST: begin
          foreach (motor_w[k]) motor_w[k] = '0;
          mode = fwdpm_pkg::DS_IDLE;
        end
        fwdpm_pkg::CMD_FWD, fwdpm_pkg::CMD_REV, fwdpm_pkg::CMD_CW,
        fwdpm_pkg::CMD_CCW, fwdpm_pkg::CMD_STRAFE_L, fwdpm_pkg::CMD_STRAFE_R: begin
          idx = int'(c.command) - int'(fwdpm_pkg::CMD_FWD);
          w   = pct_to_counts(d, cfg.motor_period);
          foreach (motor_w[k]) motor_w[k] = w;
          case (idx)
            0: pins = 8'h55;
            1: pins = 8'hAA;
            2: pins = 8'h99;
            3: pins = 8'h66;
            4: pins = 8'h96;
            default: pins = 8'h69;
          endcase
          mode  = fwdpm_pkg::drive_state_t'(int'(fwdpm_pkg::DS_FWD) + idx);
          moves = c.target;
        end
        fwdpm_pkg::CMD_TRIM_FWD: begin
          mix = '{d - a, d + a, d + b, d - b};
          trim = 1'b1;
        end
        fwdpm_pkg::CMD_TRIM_REV: begin
          mix = '{d + a, d - a, d - b, d + b};
          trim = 1'b1;
        end
        fwdpm_pkg::CMD_TRIM_LEFT: begin
          mix = '{d + a, d - b, d - a, d + b};
          trim = 1'b1;
        end
        fwdpm_pkg::CMD_TRIM_RIGHT: begin
          mix = '{d - a, d + b, d + a, d - b};
          trim = 1'b1;
        end
        fwdpm_pkg::CMD_PAN_DUTY:  pan_w  = pct_to_counts(d, cfg.pan_period);
        fwdpm_pkg::CMD_TILT_DUTY: tilt_w = pct_to_counts(d, cfg.tilt_period);
        fwdpm_pkg::CMD_PAN_LEFT:
          pan_w = pct_to_counts(cap_pct(cfg.pan_left_duty), cfg.pan_period);
        fwdpm_pkg::CMD_PAN_CENTER:
          pan_w = pct_to_counts(cap_pct(cfg.pan_center_duty), cfg.pan_period);
        fwdpm_pkg::CMD_PAN_RIGHT:
          pan_w = pct_to_counts(cap_pct(cfg.pan_right_duty), cfg.pan_period);
        default: ;
      endcase
      if (trim) begin
        foreach (motor_w[k]) motor_w[k] = pct_to_counts(clamp_trim(mix[k]), cfg.motor_period);
      end
      owed.push_back('{motor_w[0], motor_w[1], motor_w[2], motor_w[3],
                       pins, pan_w, tilt_w, mode, moves});
    endfunction

    function void report(string what, longint exp_v, longint got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0d, got %0d", what, exp_v, got_v);
    endfunction

    function void compare_field(string what, longint exp_v, longint got_v);
      if (exp_v != got_v) report(what, exp_v, got_v);
    endfunction

    function void check_status(drive_status_t got);
      drive_status_t exp_s;
      if (owed.size() == 0) begin
        report("status count (status with no command pending)", 0, 1);
        return;
      end
      exp_s = owed.pop_front();
      compare_field("width_m1",    exp_s.m1,    got.m1);
      compare_field("width_m2",    exp_s.m2,    got.m2);
      compare_field("width_m3",    exp_s.m3,    got.m3);
      compare_field("width_m4",    exp_s.m4,    got.m4);
      compare_field("bridge_pins", exp_s.pins,  got.pins);
      compare_field("pan_width",   exp_s.pan,   got.pan);
      compare_field("tilt_width",  exp_s.tilt,  got.tilt);
      compare_field("drive_state", exp_s.state, got.state);
      compare_field("move_count",  exp_s.count, got.count);
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, channels, configuration port and the block itself
  // -------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fwdpm_cmd_if cmd_ch ();
  fwdpm_res_if stat_ch ();

  four_wheel_drive_pwm_mixer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_ch),
    .out_chan (stat_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  drive_status_board board = new();

  // Idle knobs, percent of cycles; hold_request asks the receiver for a long
  // stall that it counts down on its own.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up if the run hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long counted hold-off when asked.
  initial begin
    stat_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        stat_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        stat_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watch both channels. Values are sampled before this edge's updates land,
  // so what is seen here is exactly what the block took or gave.
  always @(posedge clk) begin : watch_channels
    drive_cmd_t    taken;
    drive_status_t got;
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      taken = '{cmd_ch.command, cmd_ch.duty, cmd_ch.move_target,
                cmd_ch.correction_a, cmd_ch.correction_b};
      board.note_cmd(taken);
    end
    if (rst_n && stat_ch.valid && stat_ch.ready) begin
      got = '{stat_ch.width_m1, stat_ch.width_m2, stat_ch.width_m3, stat_ch.width_m4,
              stat_ch.bridge_pins, stat_ch.pan_width, stat_ch.tilt_width,
              fwdpm_pkg::drive_state_t'(stat_ch.drive_state), stat_ch.move_count};
      board.check_status(got);
    end
  end

  // -------------------------------------------------------------------------
  // Driving tasks; each one starts and ends right after a rising edge.
  // -------------------------------------------------------------------------
  function automatic drive_cmd_t make_cmd(logic [CMD_W-1:0] c, int d, int t, int a, int b);
    drive_cmd_t it;
    it.command = c;
    it.duty    = PCT_W'(d);
    it.target  = COUNT_W'(t);
    it.corr_a  = CORR_W'(a);
    it.corr_b  = CORR_W'(b);
    return it;
  endfunction

  function automatic drive_cmd_t random_cmd();
    drive_cmd_t it;
    // Mostly real commands, a few ignored codes; now and then an over-range duty.
    if ($urandom_range(0, 99) < 8)
      it.command = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    else
      it.command = CMD_W'($urandom_range(fwdpm_pkg::CMD_BRAKE, fwdpm_pkg::CMD_PAN_RIGHT));
    if ($urandom_range(0, 9) == 0)
      it.duty = PCT_W'($urandom_range(PCT_FULL + 1, 127));
    else
      it.duty = PCT_W'($urandom_range(0, PCT_FULL));
    it.target = COUNT_W'($urandom);
    it.corr_a = CORR_W'($urandom);
    it.corr_b = CORR_W'($urandom);
    return it;
  endfunction

  // Offer one item, with random idle cycles in front, and hold it until taken.
  task automatic send_cmd(drive_cmd_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= it.command;
    cmd_ch.duty         <= it.duty;
    cmd_ch.move_target  <= it.target;
    cmd_ch.correction_a <= it.corr_a;
    cmd_ch.correction_b <= it.corr_b;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Drop valid and wait for every owed status, then let the pipeline empty.
  // Wait for a clock edge first so the last accepted item is already on the board.
  task automatic settle_outputs();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen.
  // Leave one idle cycle after the access before the next transfer.
  task automatic cfg_write(fwdpm_pkg::reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic cfg_all(int upper, int lower, int mper, int pper, int tper,
                         int pleft, int pcenter, int pright);
    cfg_write(fwdpm_pkg::REG_UPPER_LIMIT, upper);
    cfg_write(fwdpm_pkg::REG_LOWER_LIMIT, lower);
    cfg_write(fwdpm_pkg::REG_MOTOR_PER,   mper);
    cfg_write(fwdpm_pkg::REG_PAN_PER,     pper);
    cfg_write(fwdpm_pkg::REG_TILT_PER,    tper);
    cfg_write(fwdpm_pkg::REG_PAN_LEFT,    pleft);
    cfg_write(fwdpm_pkg::REG_PAN_CENTER,  pcenter);
    cfg_write(fwdpm_pkg::REG_PAN_RIGHT,   pright);
  endtask

  // Field extremes, every command and each special case, on reset settings.
  task automatic run_directed();
    send_cmd(make_cmd(fwdpm_pkg::CMD_FWD,        100, 255,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_REV,          0,   0,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_CW,         127,  17,    0,    0)); // duty saturates
    send_cmd(make_cmd(fwdpm_pkg::CMD_CCW,         50, 128,   -1,   -1));
    send_cmd(make_cmd(fwdpm_pkg::CMD_STRAFE_L,    33,   1,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_STRAFE_R,    99,  64,    0,    0));
    // widths and count stay
    send_cmd(make_cmd(fwdpm_pkg::CMD_BRAKE,      100, 200,  127, -128));
    send_cmd(make_cmd(fwdpm_pkg::CMD_FWD,         75,  42,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_COAST,       60,  99,    0,    0)); // pins, count stay
    // sums far past both limits
    send_cmd(make_cmd(fwdpm_pkg::CMD_TRIM_FWD,   100,   5,  127, -128));
    send_cmd(make_cmd(fwdpm_pkg::CMD_TRIM_REV,     0,   5, -128,  127));
    send_cmd(make_cmd(fwdpm_pkg::CMD_TRIM_LEFT,   50,   5,   30,  -20));
    send_cmd(make_cmd(fwdpm_pkg::CMD_TRIM_RIGHT,  50,   5,  -30,   20));
    send_cmd(make_cmd(fwdpm_pkg::CMD_TRIM_FWD,   127,   5,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_PAN_DUTY,   100,   0,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_TILT_DUTY,  127,   0,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_PAN_LEFT,    10,   0,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_PAN_CENTER,  10,   0,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_PAN_RIGHT,   10,   0,    0,    0));
    send_cmd(make_cmd(fwdpm_pkg::CMD_TILT_DUTY,    0,   0,    0,    0));
    send_cmd(make_cmd(CMD_FIRST_UNUSED, 100, 255, 127,  127)); // ignored code
    send_cmd(make_cmd(CMD_LAST_UNUSED,  127, 255,  -1,   -1)); // all bits set
    send_cmd(make_cmd(fwdpm_pkg::CMD_BRAKE,        0,   0,    0,    0));
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero.
    rst_n               <= 1'b0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.command      <= '0;
    cmd_ch.duty         <= '0;
    cmd_ch.move_target  <= '0;
    cmd_ch.correction_a <= '0;
    cmd_ch.correction_b <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    settle_outputs();

    for (int phase = 0; phase < 4; phase++) begin
      // Registers change only while nothing is in flight.
      case (phase)
        0: cfg_all(127, 0, 65535, 65535, 65535, 127, 100, 0);
        1: cfg_all(0, 127, 0, 1, 0, 0, 50, 101);          // crossed limits, zero motor and tilt periods
        2: cfg_all(70, 30, $urandom_range(1, 65535), $urandom_range(1, 65535),
                   $urandom_range(1, 65535), $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom_range(0, 127));
        default: cfg_all($urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 127));
      endcase

      // Idle pattern per phase: none, sender gaps, receiver stalls, light mix.
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // With no idling, stall the receiver for a long stretch while items
        // keep coming, so the pipeline fills and backs up the input.
        if (phase == 0 && n == 40) hold_request = LONG_HOLD_CYCLES;
        // Halfway through, stop sending until the block has caught up.
        if (n == RANDOM_PER_PHASE / 2) settle_outputs();
        send_cmd(random_cmd());
      end
      settle_outputs();
    end

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
